// ===== rtl/far_pkg.sv =====
// ----------------------------------------------------------------------------
// far_pkg: shared constants and types for the fraction arithmetic unit
// operand widths, derived datapath widths, operation and result kind codes
// ----------------------------------------------------------------------------
package far_pkg;

    // numerator width; denominators are one bit narrower
    localparam int OPERAND_BITS = 16;
    localparam int NUM_W        = OPERAND_BITS;
    localparam int DEN_W        = OPERAND_BITS - 1;

    // fixed output field widths
    localparam int NUM_OUT_W = 32;
    localparam int DEN_OUT_W = 30;

    // magnitude width of products and of the sum of two products
    localparam int GW  = 2 * OPERAND_BITS - 1;
    localparam int PW  = 2 * OPERAND_BITS;
    localparam int SW  = GW + 1;
    localparam int KW  = $clog2(GW + 1);
    localparam int CW  = $clog2(GW);

    // widths used to sign or zero extend before cutting to the output fields
    localparam int OUT_EXT_W = (GW + 1 > NUM_OUT_W) ? GW + 1 : NUM_OUT_W;
    localparam int DEN_EXT_W = (GW + 1 > DEN_OUT_W) ? GW + 1 : DEN_OUT_W;

    // operation codes
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    // result kind codes
    localparam logic [1:0] KIND_ZERO    = 2'd0;
    localparam logic [1:0] KIND_WHOLE   = 2'd1;
    localparam logic [1:0] KIND_FRACT   = 2'd2;
    localparam logic [1:0] KIND_DIVZERO = 2'd3;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MUL_DEN = 9'b000000010,
        ST_MUL_T1  = 9'b000000100,
        ST_MUL_T2  = 9'b000001000,
        ST_COMBINE = 9'b000010000,
        ST_GCD     = 9'b000100000,
        ST_DIV_NUM = 9'b001000000,
        ST_DIV_DEN = 9'b010000000,
        ST_FINISH  = 9'b100000000
    } state_t;

endpackage

// ===== rtl/fraction_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_arith_reduce: signed fraction add, subtract, multiply, divide
// cross-multiplies, reduces by the greatest common divisor, flags zero divisor
// ----------------------------------------------------------------------------
// sequence: a multiply step for the denominator, one or two for the numerator terms,
//   a combine step, a binary gcd, two restoring divisions and a finish step;
//   zero and divide-by-zero results go from the combine step straight to finish
// throughput: one request at a time; in_ready is high only when idle, and the
//   finish step waits while an earlier result is still held on the output
// reset: rst_n clears the sequencer and the output valid flag at once
module fraction_arith_reduce
    import far_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  mode,
    input  logic signed [NUM_W-1:0]     left_num,
    input  logic [DEN_W-1:0]            left_den,
    input  logic signed [NUM_W-1:0]     right_num,
    input  logic [DEN_W-1:0]            right_den,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [NUM_OUT_W-1:0] result_num,
    output logic [DEN_OUT_W-1:0]        result_den,
    output logic [1:0]                  result_kind
);

    // sequencer and output handshake
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // captured operands in sign-magnitude form
    logic [1:0]       mode_reg, mode_next;
    logic             ln_neg_reg, ln_neg_next;
    logic             rn_neg_reg, rn_neg_next;
    logic [NUM_W-1:0] ln_mag_reg, ln_mag_next;
    logic [NUM_W-1:0] rn_mag_reg, rn_mag_next;
    logic [DEN_W-1:0] ld_reg, ld_next;
    logic [DEN_W-1:0] rd_reg, rd_next;

    // products
    logic [GW-1:0] den_reg, den_next;
    logic [GW-1:0] t1_reg, t1_next;
    logic [GW-1:0] t2_reg, t2_next;

    // unreduced value, later replaced by the quotients
    logic          neg_reg, neg_next;
    logic [GW-1:0] num_mag_reg, num_mag_next;
    logic [GW-1:0] den_val_reg, den_val_next;
    logic          spec_reg, spec_next;
    logic [1:0]    kind_reg, kind_next;

    // gcd working registers; ga holds the divisor once the gcd is found
    logic [GW-1:0] ga_reg, ga_next;
    logic [GW-1:0] gb_reg, gb_next;
    logic [KW-1:0] gk_reg, gk_next;

    // divider
    logic [GW-1:0] rem_reg, rem_next;
    logic [GW-1:0] dq_reg, dq_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // output payload
    logic signed [NUM_OUT_W-1:0] res_num_reg, res_num_next;
    logic [DEN_OUT_W-1:0]        res_den_reg, res_den_next;
    logic [1:0]                  res_kind_reg, res_kind_next;

    // shared multiplier
    logic [NUM_W-1:0] mul_a, mul_b;
    logic [PW-1:0]    mul_p;

    // shared subtractor, extra top bit is the borrow
    logic [SW-1:0] sub_a, sub_b;
    logic [SW:0]   sub_full;
    logic          sub_borrow;

    // helpers
    logic [NUM_W-1:0]     ln_raw, rn_raw;
    logic [SW-1:0]        rem_sh;
    logic [GW-1:0]        comb_mag;
    logic                 comb_neg;
    logic                 t1_ge_t2;
    logic                 ga_gt_gb;
    logic [OUT_EXT_W-1:0] num_ext;
    logic [DEN_EXT_W-1:0] den_ext;
    logic                 in_acc;
    logic                 out_free;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign result_num  = res_num_reg;
    assign result_den  = res_den_reg;
    assign result_kind = res_kind_reg;

    assign ln_raw = left_num;
    assign rn_raw = right_num;

    assign mul_p      = mul_a * mul_b;
    assign sub_full   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_full[SW];

    assign t1_ge_t2 = (t1_reg >= t2_reg);
    assign ga_gt_gb = (ga_reg > gb_reg);
    assign rem_sh   = {rem_reg, dq_reg[GW-1]};

    // multiplier operand select per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_DEN:
            begin
                mul_a = NUM_W'(ld_reg);
                mul_b = (mode_reg == MODE_DIV) ? rn_mag_reg : NUM_W'(rd_reg);
            end
            ST_MUL_T1:
            begin
                mul_a = ln_mag_reg;
                mul_b = (mode_reg == MODE_MUL) ? rn_mag_reg : NUM_W'(rd_reg);
            end
            ST_MUL_T2:
            begin
                mul_a = rn_mag_reg;
                mul_b = NUM_W'(ld_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // subtractor operand select: term difference, gcd step, division step
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            ST_COMBINE:
            begin
                sub_a = t1_ge_t2 ? SW'(t1_reg) : SW'(t2_reg);
                sub_b = t1_ge_t2 ? SW'(t2_reg) : SW'(t1_reg);
            end
            ST_GCD:
            begin
                sub_a = ga_gt_gb ? SW'(ga_reg) : SW'(gb_reg);
                sub_b = ga_gt_gb ? SW'(gb_reg) : SW'(ga_reg);
            end
            ST_DIV_NUM, ST_DIV_DEN:
            begin
                sub_a = rem_sh;
                sub_b = SW'(ga_reg);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    // signed sum of the two cross terms, or the single product
    always_comb
    begin
        comb_mag = t1_reg;
        comb_neg = ln_neg_reg ^ rn_neg_reg;
        if (mode_reg == MODE_ADD || mode_reg == MODE_SUB)
        begin
            if (ln_neg_reg == rn_neg_reg)
            begin
                comb_mag = t1_reg + t2_reg;
                comb_neg = ln_neg_reg;
            end
            else
            begin
                comb_mag = sub_full[GW-1:0];
                comb_neg = t1_ge_t2 ? ln_neg_reg : rn_neg_reg;
            end
        end
    end

    // output formatting: sign onto the numerator, cut to field widths
    always_comb
    begin
        num_ext = OUT_EXT_W'(num_mag_reg);
        if (neg_reg)
        begin
            num_ext = '0 - num_ext;
        end
        den_ext = DEN_EXT_W'(den_val_reg);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        ln_neg_next    = ln_neg_reg;
        rn_neg_next    = rn_neg_reg;
        ln_mag_next    = ln_mag_reg;
        rn_mag_next    = rn_mag_reg;
        ld_next        = ld_reg;
        rd_next        = rd_reg;
        den_next       = den_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        neg_next       = neg_reg;
        num_mag_next   = num_mag_reg;
        den_val_next   = den_val_reg;
        spec_next      = spec_reg;
        kind_next      = kind_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        gk_next        = gk_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        cnt_next       = cnt_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_kind_next  = res_kind_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // most negative code keeps its magnitude in the unsigned form
                    mode_next   = mode;
                    ln_neg_next = ln_raw[NUM_W-1];
                    ln_mag_next = ln_raw[NUM_W-1] ? ('0 - ln_raw) : ln_raw;
                    rn_neg_next = rn_raw[NUM_W-1] ^ (mode == MODE_SUB);
                    rn_mag_next = rn_raw[NUM_W-1] ? ('0 - rn_raw) : rn_raw;
                    ld_next     = left_den;
                    rd_next     = right_den;
                    state_next  = ST_MUL_DEN;
                end
            end
            ST_MUL_DEN:
            begin
                den_next   = mul_p[GW-1:0];
                state_next = ST_MUL_T1;
            end
            ST_MUL_T1:
            begin
                t1_next = mul_p[GW-1:0];
                if (mode_reg == MODE_ADD || mode_reg == MODE_SUB)
                begin
                    state_next = ST_MUL_T2;
                end
                else
                begin
                    state_next = ST_COMBINE;
                end
            end
            ST_MUL_T2:
            begin
                t2_next    = mul_p[GW-1:0];
                state_next = ST_COMBINE;
            end
            ST_COMBINE:
            begin
                neg_next = comb_neg;
                if (den_reg == '0)
                begin
                    // zero denominator
                    neg_next     = 1'b0;
                    num_mag_next = '0;
                    den_val_next = '0;
                    spec_next    = 1'b1;
                    kind_next    = KIND_DIVZERO;
                    state_next   = ST_FINISH;
                end
                else if (comb_mag == '0)
                begin
                    neg_next     = 1'b0;
                    num_mag_next = '0;
                    den_val_next = GW'(1);
                    spec_next    = 1'b1;
                    kind_next    = KIND_ZERO;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    num_mag_next = comb_mag;
                    den_val_next = den_reg;
                    spec_next    = 1'b0;
                    ga_next      = comb_mag;
                    gb_next      = den_reg;
                    gk_next      = '0;
                    state_next   = ST_GCD;
                end
            end
            ST_GCD:
            begin
                // binary gcd, one step a cycle
                if (ga_reg == gb_reg)
                begin
                    ga_next    = ga_reg << gk_reg;
                    rem_next   = '0;
                    dq_next    = num_mag_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV_NUM;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + KW'(1);
                end
                else if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (ga_gt_gb)
                begin
                    ga_next = sub_full[GW-1:0] >> 1;
                end
                else
                begin
                    gb_next = sub_full[GW-1:0] >> 1;
                end
            end
            ST_DIV_NUM, ST_DIV_DEN:
            begin
                // restoring division, one quotient bit a cycle
                rem_next = sub_borrow ? rem_sh[GW-1:0] : sub_full[GW-1:0];
                dq_next  = {dq_reg[GW-2:0], !sub_borrow};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(GW - 1))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == ST_DIV_NUM)
                    begin
                        num_mag_next = {dq_reg[GW-2:0], !sub_borrow};
                        dq_next      = den_val_reg;
                        state_next   = ST_DIV_DEN;
                    end
                    else
                    begin
                        den_val_next = {dq_reg[GW-2:0], !sub_borrow};
                        state_next   = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_num_next   = num_ext[NUM_OUT_W-1:0];
                    res_den_next   = den_ext[DEN_OUT_W-1:0];
                    if (spec_reg)
                    begin
                        res_kind_next = kind_reg;
                    end
                    else if (den_val_reg == GW'(1))
                    begin
                        res_kind_next = KIND_WHOLE;
                    end
                    else
                    begin
                        res_kind_next = KIND_FRACT;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        ln_neg_reg   <= ln_neg_next;
        rn_neg_reg   <= rn_neg_next;
        ln_mag_reg   <= ln_mag_next;
        rn_mag_reg   <= rn_mag_next;
        ld_reg       <= ld_next;
        rd_reg       <= rd_next;
        den_reg      <= den_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        neg_reg      <= neg_next;
        num_mag_reg  <= num_mag_next;
        den_val_reg  <= den_val_next;
        spec_reg     <= spec_next;
        kind_reg     <= kind_next;
        ga_reg       <= ga_next;
        gb_reg       <= gb_next;
        gk_reg       <= gk_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        cnt_reg      <= cnt_next;
        res_num_reg  <= res_num_next;
        res_den_reg  <= res_den_next;
        res_kind_reg <= res_kind_next;
    end

    // busy after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("block ready right after accepting a request");

    // gcd operands never reach zero
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD) |-> (ga_reg != '0) && (gb_reg != '0))
        else $error("gcd operand became zero");

    // divide-by-zero result has zero fields
    a_divzero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_kind_reg == KIND_DIVZERO)
            |-> (res_den_reg == '0) && (res_num_reg == '0))
        else $error("divide-by-zero result with nonzero fields");

    // zero result is 0/1
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_kind_reg == KIND_ZERO)
            |-> (res_num_reg == '0) && (res_den_reg == DEN_OUT_W'(1)))
        else $error("zero result not 0/1");

    // whole result has unit denominator
    a_whole_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_kind_reg == KIND_WHOLE) |-> (res_den_reg == DEN_OUT_W'(1)))
        else $error("whole result with denominator other than one");

endmodule

// ===== tb/fraction_arith_reduce_checker.sv =====
// ----------------------------------------------------------------------------
// fraction_arith_reduce_checker: result predictor and scoreboard
// watches both channels, works out each reduced fraction and compares fields
// ----------------------------------------------------------------------------
module fraction_arith_reduce_checker
    import far_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  mode,
    input  logic signed [NUM_W-1:0]     left_num,
    input  logic [DEN_W-1:0]            left_den,
    input  logic signed [NUM_W-1:0]     right_num,
    input  logic [DEN_W-1:0]            right_den,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [NUM_OUT_W-1:0] result_num,
    input  logic [DEN_OUT_W-1:0]        result_den,
    input  logic [1:0]                  result_kind,
    output int                          mismatches,
    output int                          results_seen,
    output int                          outstanding,
    output int                          divzero_seen
);

    typedef struct packed {
        logic signed [NUM_OUT_W-1:0] num;
        logic [DEN_OUT_W-1:0]        den;
        logic [1:0]                  kind;
    } fraction_t;

    fraction_t expected_fractions[$];

    // exact cross-multiplied value, then reduced by the greatest common divisor
    function automatic fraction_t reduce_fraction(
        input logic [1:0]              op,
        input logic signed [NUM_W-1:0] ln,
        input logic [DEN_W-1:0]        ld,
        input logic signed [NUM_W-1:0] rn,
        input logic [DEN_W-1:0]        rd
    );
        fraction_t r;
        longint    lnv, ldv, rnv, rdv;
        longint    n, d, a, b, t;
        lnv = ln;
        rnv = rn;
        ldv = ld;
        rdv = rd;
        case (op)
            MODE_ADD:
            begin
                n = lnv * rdv + rnv * ldv;
                d = ldv * rdv;
            end
            MODE_SUB:
            begin
                n = lnv * rdv - rnv * ldv;
                d = ldv * rdv;
            end
            MODE_MUL:
            begin
                n = lnv * rnv;
                d = ldv * rdv;
            end
            default:
            begin
                n = lnv * rdv;
                d = ldv * rnv;
                // sign of the divisor moves onto the numerator
                if (d < 0)
                begin
                    n = -n;
                    d = -d;
                end
            end
        endcase
        if (d == 0)
        begin
            r.num  = '0;
            r.den  = '0;
            r.kind = KIND_DIVZERO;
        end
        else if (n == 0)
        begin
            r.num  = '0;
            r.den  = DEN_OUT_W'(1);
            r.kind = KIND_ZERO;
        end
        else
        begin
            a = (n < 0) ? -n : n;
            b = d;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            n = n / a;
            d = d / a;
            r.num  = n[NUM_OUT_W-1:0];
            r.den  = d[DEN_OUT_W-1:0];
            r.kind = (d == 1) ? KIND_WHOLE : KIND_FRACT;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 100)
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        fraction_t want;
        if (!rst_n)
        begin
            expected_fractions.delete();
            mismatches   = 0;
            results_seen <= 0;
            outstanding  <= 0;
            divzero_seen <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_fractions.push_back(
                    reduce_fraction(mode, left_num, left_den, right_num, right_den));
            if (out_valid && out_ready)
            begin
                if (expected_fractions.size() == 0)
                    report_mismatch("unrequested result, kind", result_kind, -1);
                else
                begin
                    want = expected_fractions.pop_front();
                    if (result_num !== want.num)
                        report_mismatch("result_num", result_num, want.num);
                    if (result_den !== want.den)
                        report_mismatch("result_den", result_den, want.den);
                    if (result_kind !== want.kind)
                        report_mismatch("result_kind", result_kind, want.kind);
                end
                if (result_kind == KIND_DIVZERO)
                    divzero_seen <= divzero_seen + 1;
                results_seen <= results_seen + 1;
            end
            outstanding <= expected_fractions.size();
        end
    end

endmodule

// ===== tb/fraction_arith_reduce_tb.sv =====
// ----------------------------------------------------------------------------
// fraction_arith_reduce_tb: stimulus and verdict for the fraction unit
// directed corner requests, then three random phases under varying idling,
// one long output stall; results are checked by a separate checker module
// ----------------------------------------------------------------------------
module fraction_arith_reduce_tb;
    import far_pkg::*;

    // largest and smallest operand values the ports can carry
    localparam int NUM_MAX = 2 ** (NUM_W - 1) - 1;
    localparam int NUM_MIN = -(2 ** (NUM_W - 1));
    localparam int DEN_MAX = 2 ** DEN_W - 1;

    // watchdog limit, with a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT = 500000;
    // long output stall, far beyond one pass through the gcd and dividers
    localparam int HOLD_CYCLES = 400;
    // settle time after the last result
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_PER_PHASE = 130;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic [1:0]                  mode        = MODE_ADD;
    logic signed [NUM_W-1:0]     left_num    = '0;
    logic [DEN_W-1:0]            left_den    = 1;
    logic signed [NUM_W-1:0]     right_num   = '0;
    logic [DEN_W-1:0]            right_den   = 1;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic signed [NUM_OUT_W-1:0] result_num;
    logic [DEN_OUT_W-1:0]        result_den;
    logic [1:0]                  result_kind;

    int mismatches;
    int results_seen;
    int outstanding;
    int divzero_seen;

    // idle percentages; the sender one is only used by the stimulus process
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int requests_sent     = 0;

    // long receiver hold, requested by stimulus and counted in the receiver
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    int unsigned cycle_count = 0;

    always #4 clk = ~clk;

    fraction_arith_reduce u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .left_num    (left_num),
        .left_den    (left_den),
        .right_num   (right_num),
        .right_den   (right_den),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_num  (result_num),
        .result_den  (result_den),
        .result_kind (result_kind)
    );

    fraction_arith_reduce_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .left_num     (left_num),
        .left_den     (left_den),
        .right_num    (right_num),
        .right_den    (right_den),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_num   (result_num),
        .result_den   (result_den),
        .result_kind  (result_kind),
        .mismatches   (mismatches),
        .results_seen (results_seen),
        .outstanding  (outstanding),
        .divzero_seen (divzero_seen)
    );

    // receiver: random backpressure, or a single long hold once requested
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d of %0d results back",
                 cycle_count, results_seen, requests_sent);
        $display("end of test: mismatches");
        $finish;
    end

    // one request: optional idle gap, then hold valid and payload until taken.
    // valid is only lowered when a gap follows, so it never drops and rises
    // again within one time step
    task automatic send_request(
        input logic [1:0]              op,
        input logic signed [NUM_W-1:0] ln,
        input logic [DEN_W-1:0]        ld,
        input logic signed [NUM_W-1:0] rn,
        input logic [DEN_W-1:0]        rd
    );
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= op;
        left_num  <= ln;
        left_den  <= ld;
        right_num <= rn;
        right_den <= rd;
        // in_ready read here is the value from before the edge
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    // numerators: small values (whole and zero results), extremes, full range
    function automatic logic signed [NUM_W-1:0] pick_numerator();
        int sel;
        int v;
        sel = $urandom_range(15);
        case (sel)
            0:            v = NUM_MIN;
            1:            v = NUM_MAX;
            2:            v = -NUM_MAX;
            3:            v = 0;
            4:            v = 1;
            5:            v = -1;
            6, 7, 8, 9:   v = int'($urandom_range(40)) - 20;
            default:      v = $urandom;
        endcase
        return v[NUM_W-1:0];
    endfunction

    // denominators: a rare zero (outside the usable range), extremes, small, full
    function automatic logic [DEN_W-1:0] pick_denominator();
        int sel;
        int v;
        sel = $urandom_range(31);
        case (sel)
            0:                 v = 0;
            1, 2:              v = DEN_MAX;
            3, 4:              v = 1;
            5, 6, 7, 8, 9,
            10, 11, 12, 13:    v = $urandom_range(1, 24);
            default:           v = $urandom;
        endcase
        return v[DEN_W-1:0];
    endfunction

    task automatic send_random_requests(input int count);
        logic [1:0] op;
        repeat (count)
        begin
            op = $urandom_range(3);
            send_request(op, pick_numerator(), pick_denominator(),
                         pick_numerator(), pick_denominator());
        end
    endtask

    // sender pause: nothing offered until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (results_seen != requests_sent) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one idling: sender idles lightly, receiver about half the time
        sender_idle_pct   = 24;
        receiver_idle_pct <= 49;

        // directed: every operation, zero results, whole results, divide by
        // zero from each source, negative divisor, operand extremes
        send_request(MODE_ADD, 1, 2, 1, 3);
        send_request(MODE_SUB, 1, 2, 1, 2);
        send_request(MODE_MUL, 2, 3, 3, 2);
        send_request(MODE_DIV, 1, 2, -1, 4);
        send_request(MODE_DIV, 3, 4, 0, 5);
        send_request(MODE_ADD, 1, 0, 1, 3);
        send_request(MODE_MUL, 1, 3, 2, 0);
        send_request(MODE_DIV, 0, 7, 3, 5);
        send_request(MODE_DIV, 0, 0, 0, 1);
        send_request(MODE_MUL, NUM_MIN, 1, NUM_MIN, 1);
        send_request(MODE_SUB, NUM_MIN, 1, NUM_MAX, 1);
        send_request(MODE_ADD, NUM_MAX, DEN_MAX, NUM_MAX, 1);
        send_request(MODE_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
        send_request(MODE_MUL, NUM_MAX, DEN_MAX - 1, NUM_MAX, DEN_MAX - 2);
        send_request(MODE_DIV, NUM_MIN, 1, 1, DEN_MAX);
        send_request(MODE_DIV, NUM_MAX, 1, NUM_MIN, DEN_MAX);
        send_request(MODE_SUB, -5, 6, -5, 6);
        send_request(MODE_ADD, -1, DEN_MAX, 1, DEN_MAX);
        send_request(MODE_DIV, -7, 9, -14, 3);
        send_request(MODE_MUL, -1, 1, 1, 1);
        send_request(MODE_SUB, 0, 1, NUM_MIN, DEN_MAX);
        send_request(MODE_ADD, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);
        drain_results();

        send_random_requests(RANDOM_PER_PHASE);
        drain_results();

        // phase two: the other way round, with one long output hold at the
        // start while requests keep coming, so the unit fills and stalls input
        sender_idle_pct   = 49;
        receiver_idle_pct <= 24;
        hold_req          <= 1'b1;
        send_random_requests(RANDOM_PER_PHASE);
        drain_results();

        // phase three: back to back on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct <= 0;
        send_random_requests(RANDOM_PER_PHASE);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests over all four operations in three idle mixes",
                 requests_sent);
        $display("plus a %0d-cycle output hold; %0d results checked, %0d divide by zero",
                 HOLD_CYCLES, results_seen, divzero_seen);
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/far_pkg.sv
rtl/fraction_arith_reduce.sv
tb/fraction_arith_reduce_checker.sv
tb/fraction_arith_reduce_tb.sv
